// ===== hw/rtl/circle_circle_contact_top_defines.svh =====
// Assertion macros shared by the circle contact RTL.
// Expects i_clk and i_rst_n in the scope of each use.
`ifndef CIRCLE_CIRCLE_CONTACT_TOP_DEFINES_SVH
`define CIRCLE_CIRCLE_CONTACT_TOP_DEFINES_SVH

// same-cycle implication
`define CCC_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CCC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/ccc_pkg.sv =====
// Package for the circle contact block: widths, payload and stage types,
// and the per-step sqrt / divide functions and coordinate saturation. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ccc_pkg;

    localparam int CW      = 24;              // coordinate width
    localparam int RADW    = CW - 1;          // radius width
    localparam int GUARD   = 31 - CW;         // extra fraction bits of the distance
    localparam int AXW     = CW + 1;          // center difference
    localparam int SW      = CW + 2;          // center sum
    localparam int RSW     = CW;              // radius sum
    localparam int DRW     = CW;              // radius difference, signed
    localparam int PRODW   = AXW + DRW;       // diff * dr
    localparam int DIST_W  = 2 * AXW;         // squared distance
    localparam int RAD_W   = DIST_W + 2 * GUARD;
    localparam int ROOT_W  = RAD_W / 2;
    localparam int DEN_W   = ROOT_W + 1;
    localparam int NUM_W   = SW + ROOT_W + 2;
    localparam int M_W     = NUM_W;
    localparam int Q_W     = CW + 2;
    localparam int STEPS   = 2;               // iterations per stage
    localparam int SQ_STG  = (ROOT_W + STEPS - 1) / STEPS;
    localparam int DV_STG  = (Q_W + STEPS - 1) / STEPS;

    localparam logic signed [Q_W:0] SAT_HI = (Q_W + 1)'((64'sd1 <<< (CW - 1)) - 64'sd1);
    localparam logic signed [Q_W:0] SAT_LO = -SAT_HI - (Q_W + 1)'(1);

    typedef struct packed {
        logic signed [CW-1:0]   first_center_x;
        logic signed [CW-1:0]   first_center_y;
        logic        [RADW-1:0] first_radius;
        logic signed [CW-1:0]   second_center_x;
        logic signed [CW-1:0]   second_center_y;
        logic        [RADW-1:0] second_radius;
    } t_req;

    typedef struct packed {
        logic                 overlapping;
        logic                 concentric;
        logic signed [CW-1:0] contact_x;
        logic signed [CW-1:0] contact_y;
    } t_rsp;

    // sideband through the sqrt pipe
    typedef struct packed {
        logic                    ovl;
        logic                    conc;
        logic signed [CW-1:0]    x1;
        logic signed [CW-1:0]    y1;
        logic signed [SW-1:0]    sx;
        logic signed [SW-1:0]    sy;
        logic signed [PRODW-1:0] axdr;
        logic signed [PRODW-1:0] aydr;
    } t_sq_side;

    // sideband through the divider
    typedef struct packed {
        logic                 ovl;
        logic                 conc;
        logic                 neg_x;
        logic                 neg_y;
        logic signed [CW-1:0] x1;
        logic signed [CW-1:0] y1;
    } t_dv_side;

    typedef struct packed {
        logic [RAD_W-1:0] rad;
        logic [RAD_W-1:0] res;
    } t_sq_st;

    typedef struct packed {
        logic [M_W-1:0] rem;
        logic [Q_W-1:0] q;
    } t_dv_st;

    // one iteration of the bit-by-bit square root, bit = 4^(ROOT_W-1-k)
    function automatic t_sq_st sq_step(t_sq_st s, int k);
        t_sq_st           o;
        logic [RAD_W-1:0] b;
        logic [RAD_W-1:0] t;
        o = s;
        b = RAD_W'(1) << (RAD_W - 2 - 2 * k);
        t = s.res + b;
        if (s.rad >= t) begin
            o.rad = s.rad - t;
            o.res = (s.res >> 1) + b;
        end else begin
            o.res = s.res >> 1;
        end
        return o;
    endfunction

    // one restoring-division iteration, quotient bit Q_W-1-k
    function automatic t_dv_st dv_step(t_dv_st s, logic [DEN_W-1:0] den, int k);
        t_dv_st         o;
        logic [M_W-1:0] t;
        o = s;
        t = M_W'(den) << (Q_W - 1 - k);
        if (s.rem >= t) begin
            o.rem = s.rem - t;
            o.q   = s.q | (Q_W'(1) << (Q_W - 1 - k));
        end
        return o;
    endfunction

    function automatic logic signed [CW-1:0] sat_coord(logic signed [Q_W:0] v);
        logic signed [Q_W:0] c;
        c = v;
        if (v > SAT_HI) begin
            c = SAT_HI;
        end else if (v < SAT_LO) begin
            c = SAT_LO;
        end
        return c[CW-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/ccc_if.sv =====
// Request and response channels of the circle contact block.
// Depends on ccc_pkg for the payload types.
`timescale 1ns / 1ps
`default_nettype none

interface ccc_req_if import ccc_pkg::*; ();
    logic valid;
    logic ready;
    t_req data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface ccc_rsp_if import ccc_pkg::*; ();
    logic valid;
    logic ready;
    t_rsp data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/ccc_sqrt.sv =====
// Pipelined integer square root, STEPS iterations per stage, with sideband.
// Depends on ccc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ccc_sqrt import ccc_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire logic [RAD_W-1:0]  i_rad,
    input  wire t_sq_side          i_side,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output logic [ROOT_W-1:0]      o_root,
    output t_sq_side               o_side
);

    logic     [SQ_STG-1:0] r_v;
    logic     [SQ_STG-1:0] w_en;
    t_sq_st                r_st   [SQ_STG];
    t_sq_side              r_side [SQ_STG];
    t_sq_st                n_st   [SQ_STG];

    for (genvar s = 0; s < SQ_STG; s++) begin : g_stg
        t_sq_st   w_in;
        t_sq_side w_side;
        logic     w_vin;

        if (s == 0) begin : g_first
            assign w_in   = '{rad: i_rad, res: '0};
            assign w_side = i_side;
            assign w_vin  = i_valid;
        end else begin : g_next
            assign w_in   = r_st[s-1];
            assign w_side = r_side[s-1];
            assign w_vin  = r_v[s-1];
        end

        if (s == SQ_STG - 1) begin : g_last_en
            assign w_en[s] = !r_v[s] || i_ready;
        end else begin : g_mid_en
            assign w_en[s] = !r_v[s] || w_en[s+1];
        end

        always_comb begin
            t_sq_st t;
            t = w_in;
            for (int j = 0; j < STEPS; j++) begin
                if (s * STEPS + j < ROOT_W) begin
                    t = sq_step(t, s * STEPS + j);
                end
            end
            n_st[s] = t;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s] <= 1'b0;
            end else if (w_en[s]) begin
                r_v[s] <= w_vin;
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en[s]) begin
                r_st[s]   <= n_st[s];
                r_side[s] <= w_side;
            end
        end
    end

    assign o_ready = w_en[0];
    assign o_valid = r_v[SQ_STG-1];
    assign o_root  = r_st[SQ_STG-1].res[ROOT_W-1:0];
    assign o_side  = r_side[SQ_STG-1];

endmodule

`default_nettype wire

// ===== hw/rtl/ccc_div.sv =====
// Two-lane pipelined restoring divider sharing one divisor, with sideband.
// Depends on ccc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ccc_div import ccc_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire logic [DEN_W-1:0]  i_den,
    input  wire logic [M_W-1:0]    i_mx,
    input  wire logic [M_W-1:0]    i_my,
    input  wire t_dv_side          i_side,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output logic [Q_W-1:0]         o_qx,
    output logic [Q_W-1:0]         o_qy,
    output t_dv_side               o_side
);

    logic [DV_STG-1:0] r_v;
    logic [DV_STG-1:0] w_en;
    t_dv_st            r_x    [DV_STG];
    t_dv_st            r_y    [DV_STG];
    logic [DEN_W-1:0]  r_den  [DV_STG];
    t_dv_side          r_side [DV_STG];
    t_dv_st            n_x    [DV_STG];
    t_dv_st            n_y    [DV_STG];

    for (genvar s = 0; s < DV_STG; s++) begin : g_stg
        t_dv_st           w_x;
        t_dv_st           w_y;
        logic [DEN_W-1:0] w_den;
        t_dv_side         w_side;
        logic             w_vin;

        if (s == 0) begin : g_first
            assign w_x    = '{rem: i_mx, q: '0};
            assign w_y    = '{rem: i_my, q: '0};
            assign w_den  = i_den;
            assign w_side = i_side;
            assign w_vin  = i_valid;
        end else begin : g_next
            assign w_x    = r_x[s-1];
            assign w_y    = r_y[s-1];
            assign w_den  = r_den[s-1];
            assign w_side = r_side[s-1];
            assign w_vin  = r_v[s-1];
        end

        if (s == DV_STG - 1) begin : g_last_en
            assign w_en[s] = !r_v[s] || i_ready;
        end else begin : g_mid_en
            assign w_en[s] = !r_v[s] || w_en[s+1];
        end

        always_comb begin
            t_dv_st tx;
            t_dv_st ty;
            tx = w_x;
            ty = w_y;
            for (int j = 0; j < STEPS; j++) begin
                if (s * STEPS + j < Q_W) begin
                    tx = dv_step(tx, w_den, s * STEPS + j);
                    ty = dv_step(ty, w_den, s * STEPS + j);
                end
            end
            n_x[s] = tx;
            n_y[s] = ty;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s] <= 1'b0;
            end else if (w_en[s]) begin
                r_v[s] <= w_vin;
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en[s]) begin
                r_x[s]    <= n_x[s];
                r_y[s]    <= n_y[s];
                r_den[s]  <= w_den;
                r_side[s] <= w_side;
            end
        end
    end

    assign o_ready = w_en[0];
    assign o_valid = r_v[DV_STG-1];
    assign o_qx    = r_x[DV_STG-1].q;
    assign o_qy    = r_y[DV_STG-1].q;
    assign o_side  = r_side[DV_STG-1];

endmodule

`default_nettype wire

// ===== hw/rtl/circle_circle_contact_top.sv =====
// Top level of the circle-circle contact test: front stages, sqrt pipe,
// numerator stages, divider, output register. Depends on ccc_pkg, ccc_if,
// ccc_sqrt, ccc_div and the assertion macro header.
//
//  channel | dir | payload                                  | handshake
//  i_req   | in  | two centers (Q16.8) and two radii (Q15.8) | valid/ready
//  o_rsp   | out | overlapping, concentric, contact x/y      | valid/ready
//
// One request per cycle while o_rsp is ready; the 32-step root and 26-step
// quotient each take two steps per stage.
// Every stage holds its own valid bit and loads when empty or when the stage
// after it moves, so bubbles collapse and a stall at o_rsp backs up stage
// by stage; nothing is dropped or repeated.
// Reset (synchronous, active low) clears only the valid bits.
`timescale 1ns / 1ps
`default_nettype none
`include "circle_circle_contact_top_defines.svh"

module circle_circle_contact_top import ccc_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    ccc_req_if.sink    i_req,
    ccc_rsp_if.source  o_rsp
);

    // ---- stage 1: differences and sums ----
    logic                    r1_v;
    logic signed [AXW-1:0]   r1_ax, r1_ay;
    logic signed [SW-1:0]    r1_sx, r1_sy;
    logic        [RSW-1:0]   r1_rsum;
    logic signed [DRW-1:0]   r1_dr;
    logic signed [CW-1:0]    r1_x1, r1_y1;

    // ---- stage 2: products ----
    logic                    r2_v;
    logic signed [DIST_W-1:0] r2_ax2, r2_ay2;
    logic        [2*RSW-1:0] r2_rs2;
    logic signed [PRODW-1:0] r2_axdr, r2_aydr;
    logic signed [SW-1:0]    r2_sx, r2_sy;
    logic signed [CW-1:0]    r2_x1, r2_y1;

    // ---- stage 3: squared distance and overlap test ----
    logic                    r3_v;
    logic        [DIST_W-1:0] r3_dist;
    t_sq_side                r3_side;

    // ---- stage 4: center sum times distance ----
    logic                    r4_v;
    logic        [ROOT_W-1:0] r4_d;
    logic signed [SW+ROOT_W:0] r4_sxd, r4_syd;
    logic signed [NUM_W-1:0] r4_axg, r4_ayg;
    logic                    r4_ovl, r4_conc;
    logic signed [CW-1:0]    r4_x1, r4_y1;

    // ---- stage 5: numerators ----
    logic                    r5_v;
    logic signed [NUM_W-1:0] r5_nx, r5_ny;
    logic        [DEN_W-1:0] r5_den;
    logic                    r5_ovl, r5_conc;
    logic signed [CW-1:0]    r5_x1, r5_y1;

    // ---- stage 6: magnitudes for floor division ----
    logic                    r6_v;
    logic        [M_W-1:0]   r6_mx, r6_my;
    logic        [DEN_W-1:0] r6_den;
    t_dv_side                r6_side;

    // ---- stage 7: output register ----
    logic                    r7_v;
    t_rsp                    r7_rsp;

    logic w_en1, w_en2, w_en3, w_en4, w_en5, w_en6, w_en7;
    logic w_sq_ready, w_sq_valid, w_dv_ready, w_dv_valid;
    logic [ROOT_W-1:0] w_root;
    t_sq_side          w_sq_side;
    logic [Q_W-1:0]    w_qx, w_qy;
    t_dv_side          w_dv_side;
    logic signed [Q_W:0] w_vx, w_vy;
    t_rsp              n7_rsp;

    assign w_en7 = !r7_v || o_rsp.ready;
    assign w_en6 = !r6_v || w_dv_ready;
    assign w_en5 = !r5_v || w_en6;
    assign w_en4 = !r4_v || w_en5;
    assign w_en3 = !r3_v || w_sq_ready;
    assign w_en2 = !r2_v || w_en3;
    assign w_en1 = !r1_v || w_en2;

    assign i_req.ready = w_en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
            r5_v <= 1'b0;
            r6_v <= 1'b0;
            r7_v <= 1'b0;
        end else begin
            if (w_en1) r1_v <= i_req.valid;
            if (w_en2) r2_v <= r1_v;
            if (w_en3) r3_v <= r2_v;
            if (w_en4) r4_v <= w_sq_valid;
            if (w_en5) r5_v <= r4_v;
            if (w_en6) r6_v <= r5_v;
            if (w_en7) r7_v <= w_dv_valid;
        end
    end

    // stage 1
    always_ff @(posedge i_clk) begin
        if (w_en1) begin
            r1_ax   <= AXW'(i_req.data.second_center_x) - AXW'(i_req.data.first_center_x);
            r1_ay   <= AXW'(i_req.data.second_center_y) - AXW'(i_req.data.first_center_y);
            r1_sx   <= SW'(i_req.data.first_center_x) + SW'(i_req.data.second_center_x);
            r1_sy   <= SW'(i_req.data.first_center_y) + SW'(i_req.data.second_center_y);
            r1_rsum <= RSW'(i_req.data.first_radius) + RSW'(i_req.data.second_radius);
            r1_dr   <= $signed(DRW'(i_req.data.first_radius))
                     - $signed(DRW'(i_req.data.second_radius));
            r1_x1   <= i_req.data.first_center_x;
            r1_y1   <= i_req.data.first_center_y;
        end
    end

    // stage 2
    always_ff @(posedge i_clk) begin
        if (w_en2) begin
            r2_ax2  <= DIST_W'(r1_ax) * DIST_W'(r1_ax);
            r2_ay2  <= DIST_W'(r1_ay) * DIST_W'(r1_ay);
            r2_rs2  <= (2*RSW)'(r1_rsum) * (2*RSW)'(r1_rsum);
            r2_axdr <= PRODW'(r1_ax) * PRODW'(r1_dr);
            r2_aydr <= PRODW'(r1_ay) * PRODW'(r1_dr);
            r2_sx   <= r1_sx;
            r2_sy   <= r1_sy;
            r2_x1   <= r1_x1;
            r2_y1   <= r1_y1;
        end
    end

    // stage 3: touching counts as overlap
    always_ff @(posedge i_clk) begin
        if (w_en3) begin
            r3_dist      <= $unsigned(r2_ax2) + $unsigned(r2_ay2);
            r3_side.ovl  <= ($unsigned(r2_ax2) + $unsigned(r2_ay2)) <= DIST_W'(r2_rs2);
            r3_side.conc <= (r2_ax2 == '0) && (r2_ay2 == '0);
            r3_side.x1   <= r2_x1;
            r3_side.y1   <= r2_y1;
            r3_side.sx   <= r2_sx;
            r3_side.sy   <= r2_sy;
            r3_side.axdr <= r2_axdr;
            r3_side.aydr <= r2_aydr;
        end
    end

    // distance with GUARD extra fraction bits: floor(sqrt(dist2 * 4^GUARD))
    ccc_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r3_v),
        .o_ready (w_sq_ready),
        .i_rad   (RAD_W'(r3_dist) << (2 * GUARD)),
        .i_side  (r3_side),
        .o_valid (w_sq_valid),
        .i_ready (w_en4),
        .o_root  (w_root),
        .o_side  (w_sq_side)
    );

    // stage 4
    always_ff @(posedge i_clk) begin
        if (w_en4) begin
            r4_d    <= w_root;
            r4_sxd  <= (SW+ROOT_W+1)'(w_sq_side.sx)
                     * (SW+ROOT_W+1)'($signed({1'b0, w_root}));
            r4_syd  <= (SW+ROOT_W+1)'(w_sq_side.sy)
                     * (SW+ROOT_W+1)'($signed({1'b0, w_root}));
            r4_axg  <= NUM_W'(w_sq_side.axdr) <<< GUARD;
            r4_ayg  <= NUM_W'(w_sq_side.aydr) <<< GUARD;
            r4_ovl  <= w_sq_side.ovl;
            r4_conc <= w_sq_side.conc;
            r4_x1   <= w_sq_side.x1;
            r4_y1   <= w_sq_side.y1;
        end
    end

    // stage 5: n = S*D + a*dr*2^GUARD + D, rounding half up after /2D
    always_ff @(posedge i_clk) begin
        if (w_en5) begin
            r5_nx   <= NUM_W'(r4_sxd) + r4_axg + $signed(NUM_W'(r4_d));
            r5_ny   <= NUM_W'(r4_syd) + r4_ayg + $signed(NUM_W'(r4_d));
            r5_den  <= {r4_d, 1'b0};
            r5_ovl  <= r4_ovl;
            r5_conc <= r4_conc;
            r5_x1   <= r4_x1;
            r5_y1   <= r4_y1;
        end
    end

    // stage 6: negative n -> divide |n| + den - 1 and negate (floor)
    always_ff @(posedge i_clk) begin
        if (w_en6) begin
            r6_mx <= r5_nx[NUM_W-1]
                   ? $unsigned(-r5_nx) + M_W'(r5_den) - M_W'(1) : $unsigned(r5_nx);
            r6_my <= r5_ny[NUM_W-1]
                   ? $unsigned(-r5_ny) + M_W'(r5_den) - M_W'(1) : $unsigned(r5_ny);
            r6_den        <= r5_den;
            r6_side.ovl   <= r5_ovl;
            r6_side.conc  <= r5_conc;
            r6_side.neg_x <= r5_nx[NUM_W-1];
            r6_side.neg_y <= r5_ny[NUM_W-1];
            r6_side.x1    <= r5_x1;
            r6_side.y1    <= r5_y1;
        end
    end

    ccc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r6_v),
        .o_ready (w_dv_ready),
        .i_den   (r6_den),
        .i_mx    (r6_mx),
        .i_my    (r6_my),
        .i_side  (r6_side),
        .o_valid (w_dv_valid),
        .i_ready (w_en7),
        .o_qx    (w_qx),
        .o_qy    (w_qy),
        .o_side  (w_dv_side)
    );

    // stage 7: sign, saturate, special cases
    assign w_vx = w_dv_side.neg_x ? -$signed({1'b0, w_qx}) : $signed({1'b0, w_qx});
    assign w_vy = w_dv_side.neg_y ? -$signed({1'b0, w_qy}) : $signed({1'b0, w_qy});

    always_comb begin
        n7_rsp = '0;
        if (w_dv_side.ovl) begin
            n7_rsp.overlapping = 1'b1;
            if (w_dv_side.conc) begin
                // same center: report the first center
                n7_rsp.concentric = 1'b1;
                n7_rsp.contact_x  = w_dv_side.x1;
                n7_rsp.contact_y  = w_dv_side.y1;
            end else begin
                n7_rsp.contact_x = sat_coord(w_vx);
                n7_rsp.contact_y = sat_coord(w_vy);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en7) begin
            r7_rsp <= n7_rsp;
        end
    end

    assign o_rsp.valid = r7_v;
    assign o_rsp.data  = r7_rsp;

    `CCC_ASSERT_IMPL(a_no_ovl_zero, o_rsp.valid && !o_rsp.data.overlapping,
        !o_rsp.data.concentric && o_rsp.data.contact_x == '0 && o_rsp.data.contact_y == '0,
        "miss result carries nonzero fields")
    `CCC_ASSERT_IMPL(a_conc_ovl, o_rsp.valid && o_rsp.data.concentric,
        o_rsp.data.overlapping, "concentric without overlap")
    `CCC_ASSERT_IMPL(a_bubble_accepts, !r1_v, i_req.ready,
        "empty first stage refused a request")
    `CCC_ASSERT_NEXT(a_sqrt_stall_holds, r3_v && !w_sq_ready, r3_v && $stable(r3_dist),
        "stage 3 lost data on a stall")

endmodule

`default_nettype wire
